// ===== sv/scc_pkg.sv =====
// Shared types, constants and helpers for the strongly connected components block.
package scc_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int ROW_CAP          = 32;
  localparam int VW               = 5;   // vertex index width
  localparam int CW               = 6;   // count width (holds ROW_CAP itself)
  localparam logic [CW-1:0] NUM_RESET = 6'd32;

  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_RUN  = 1'b1
  } scc_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_CMP,
    ST_POP_RD,
    ST_POP_OUT,
    ST_RET_RD1,
    ST_RET_RD2,
    ST_RET_LOAD
  } scc_state_t;

  typedef struct packed {
    logic [CW-1:0] pos;
    logic [VW-1:0] v;
  } scc_frame_t;

  typedef struct packed {
    logic load_row;
    logic init;
    logic root_inc;
    logic push_root;
    logic push_child;
    logic scan_step;
    logic vo_rd;
    logic cmp_upd;
    logic pop_rd;
    logic pop_ack;
    logic comp_inc;
    logic ret_rd_cs;
    logic ret_rd_ll;
    logic ret_load;
  } scc_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_visited;
    logic pend_any;
    logic w_visited;
    logic w_onstk;
    logic low_eq_ord;
    logic pop_more;
    logic depth_zero;
  } scc_stat_t;

  // Index of the lowest set bit; 31 when none is set.
  function automatic logic [VW-1:0] lowest_bit(input logic [ROW_CAP-1:0] x);
    logic [VW-1:0] idx;
    idx = VW'(ROW_CAP - 1);
    for (int i = ROW_CAP - 1; i >= 0; i--) begin
      if (x[i]) idx = VW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== sv/scc_in_if.sv =====
// Input channel interface: adjacency row loads and run requests.
interface scc_in_if
  import scc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [VW-1:0]       vertex;
  logic [ROW_CAP-1:0]  targets;

  modport source (output valid, kind, vertex, targets, input ready);
  modport sink   (input valid, kind, vertex, targets, output ready);
endinterface

// ===== sv/scc_out_if.sv =====
// Result channel interface: one item per vertex popped into a component.
interface scc_out_if
  import scc_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [VW-1:0] member;
  logic [VW-1:0] component;
  logic          ends_component;
  logic          last;

  modport source (output valid, member, component, ends_component, last, input ready);
  modport sink   (input valid, member, component, ends_component, last, output ready);
endinterface

// ===== sv/scc_ctrl.sv =====
// Search sequencer: steps the depth-first walk and the component pops.
module scc_ctrl
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  logic      out_ready,
  input  scc_stat_t stat,
  output logic      in_ready,
  output logic      out_valid,
  output scc_cmd_t  cmd
);

  scc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_RUN) begin
            cmd.init  = 1'b1;
            state_nxt = ST_ROOT;
          end else begin
            cmd.load_row = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        if (stat.root_done) begin
          state_nxt = ST_IDLE;
        end else if (stat.root_visited) begin
          cmd.root_inc = 1'b1;
        end else begin
          cmd.push_root = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.pend_any) begin
          cmd.scan_step = 1'b1;
          if (!stat.w_visited) begin
            cmd.push_child = 1'b1;
          end else if (stat.w_onstk) begin
            cmd.vo_rd = 1'b1;
            state_nxt = ST_CMP;
          end
        end else if (stat.low_eq_ord) begin
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_RET_RD1;
        end
      end
      ST_CMP: begin
        cmd.cmp_upd = 1'b1;
        state_nxt   = ST_SCAN;
      end
      ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop_ack = 1'b1;
          if (stat.pop_more) begin
            state_nxt = ST_POP_RD;
          end else begin
            cmd.comp_inc = 1'b1;
            state_nxt    = ST_RET_RD1;
          end
        end
      end
      ST_RET_RD1: begin
        if (stat.depth_zero) begin
          cmd.root_inc = 1'b1;
          state_nxt    = ST_ROOT;
        end else begin
          cmd.ret_rd_cs = 1'b1;
          state_nxt     = ST_RET_RD2;
        end
      end
      ST_RET_RD2: begin
        cmd.ret_rd_ll = 1'b1;
        state_nxt     = ST_RET_LOAD;
      end
      ST_RET_LOAD: begin
        cmd.ret_load = 1'b1;
        state_nxt    = ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/scc_dpath.sv =====
// Search datapath: row store, per-vertex memories, stacks and the current frame.
module scc_dpath
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CW-1:0]      cfg_wdata,
  input  logic [VW-1:0]      in_vertex,
  input  logic [ROW_CAP-1:0] in_targets,
  input  scc_cmd_t           cmd,
  output scc_stat_t          stat,
  output logic [VW-1:0]      res_member,
  output logic [VW-1:0]      res_component,
  output logic               res_ends,
  output logic               res_last
);

  localparam int LIM = (MAX_VERTICES < ROW_CAP) ? MAX_VERTICES : ROW_CAP;
  localparam logic [CW-1:0] LIM_C = CW'(LIM);

  logic [ROW_CAP-1:0] adj_r [ROW_CAP];
  logic [ROW_CAP-1:0] visited_r, onstk_r;
  logic [CW-1:0]      num_r, vc_r, sp_r, depth_r, root_r, emit_r;
  logic [VW-1:0]      comp_r;

  logic [CW-1:0]      vo_mem   [ROW_CAP];
  logic [VW-1:0]      ll_mem   [ROW_CAP];
  logic [VW-1:0]      cs_mem   [ROW_CAP];
  scc_frame_t         call_mem [ROW_CAP];

  logic [CW-1:0]      vo_rd_r;
  logic [VW-1:0]      ll_rd_r, cs_rd_r;
  scc_frame_t         call_rd_r;

  logic [VW-1:0]      cur_v_r, cur_low_r;
  logic [CW-1:0]      cur_pos_r, cur_ord_r;

  logic [CW-1:0]      n_eff;
  logic [ROW_CAP-1:0] vmask, pmask, pending;
  logic [VW-1:0]      w, pv;
  logic [CW-1:0]      w_next;

  assign n_eff   = (num_r < LIM_C) ? num_r : LIM_C;
  assign vmask   = n_eff[CW-1] ? '1 : ((ROW_CAP'(1) << n_eff[VW-1:0]) - ROW_CAP'(1));
  assign pmask   = cur_pos_r[CW-1] ? '0 : ('1 << cur_pos_r[VW-1:0]);
  assign pending = adj_r[cur_v_r] & vmask & pmask;
  assign w       = lowest_bit(pending);
  assign w_next  = {1'b0, w} + CW'(1);
  assign pv      = cmd.push_root ? root_r[VW-1:0] : w;

  assign stat.root_done    = (root_r >= n_eff);
  assign stat.root_visited = visited_r[root_r[VW-1:0]];
  assign stat.pend_any     = |pending;
  assign stat.w_visited    = visited_r[w];
  assign stat.w_onstk      = onstk_r[w];
  assign stat.low_eq_ord   = ({1'b0, cur_low_r} == cur_ord_r);
  assign stat.pop_more     = (cs_rd_r != cur_v_r) && (sp_r > CW'(1));
  assign stat.depth_zero   = (depth_r == '0);

  assign res_member    = cs_rd_r;
  assign res_component = comp_r;
  assign res_ends      = (cs_rd_r == cur_v_r);
  assign res_last      = (emit_r == n_eff - CW'(1));

  // Control state and row store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROW_CAP; i++) adj_r[i] <= '0;
      visited_r <= '0;
      onstk_r   <= '0;
      num_r     <= NUM_RESET;
      vc_r      <= '0;
      sp_r      <= '0;
      depth_r   <= '0;
      root_r    <= '0;
      emit_r    <= '0;
      comp_r    <= '0;
    end else begin
      if (cfg_we) num_r <= cfg_wdata;
      if (cmd.load_row && ({1'b0, in_vertex} < LIM_C)) adj_r[in_vertex] <= in_targets;
      if (cmd.init) begin
        visited_r <= '0;
        onstk_r   <= '0;
        vc_r      <= '0;
        sp_r      <= '0;
        depth_r   <= '0;
        root_r    <= '0;
        emit_r    <= '0;
        comp_r    <= '0;
      end
      if (cmd.root_inc) root_r <= root_r + CW'(1);
      if (cmd.push_root || cmd.push_child) begin
        visited_r[pv] <= 1'b1;
        onstk_r[pv]   <= 1'b1;
        vc_r          <= vc_r + CW'(1);
        sp_r          <= sp_r + CW'(1);
      end
      if (cmd.push_child) depth_r <= depth_r + CW'(1);
      if (cmd.ret_load)   depth_r <= depth_r - CW'(1);
      if (cmd.pop_ack) begin
        onstk_r[cs_rd_r] <= 1'b0;
        sp_r             <= sp_r - CW'(1);
        emit_r           <= emit_r + CW'(1);
      end
      if (cmd.comp_inc) comp_r <= comp_r + VW'(1);
    end
  end

  // Memories and the current frame.
  always_ff @(posedge clk) begin
    if (cmd.push_root || cmd.push_child) begin
      vo_mem[pv]               <= vc_r;
      cs_mem[sp_r[VW-1:0]]     <= pv;
    end
    if (cmd.push_child) begin
      call_mem[depth_r[VW-1:0]] <= '{pos: w_next, v: cur_v_r};
      ll_mem[cur_v_r]           <= cur_low_r;
    end
    if (cmd.vo_rd)     vo_rd_r   <= vo_mem[w];
    if (cmd.pop_rd)    cs_rd_r   <= cs_mem[sp_r[VW-1:0] - VW'(1)];
    if (cmd.ret_rd_cs) call_rd_r <= call_mem[depth_r[VW-1:0] - VW'(1)];
    if (cmd.ret_rd_ll) begin
      ll_rd_r <= ll_mem[call_rd_r.v];
      vo_rd_r <= vo_mem[call_rd_r.v];
    end

    if (cmd.scan_step && !cmd.push_child) cur_pos_r <= w_next;
    if (cmd.push_root || cmd.push_child) begin
      cur_v_r   <= pv;
      cur_pos_r <= '0;
      cur_low_r <= vc_r[VW-1:0];
      cur_ord_r <= vc_r;
    end
    if (cmd.cmp_upd && (vo_rd_r < {1'b0, cur_low_r})) cur_low_r <= vo_rd_r[VW-1:0];
    if (cmd.ret_load) begin
      cur_v_r   <= call_rd_r.v;
      cur_pos_r <= call_rd_r.pos;
      cur_ord_r <= vo_rd_r;
      cur_low_r <= (cur_low_r < ll_rd_r) ? cur_low_r : ll_rd_r;
    end
  end

endmodule

// ===== sv/strongly_connected_components.sv =====
// Top level of the Tarjan strongly connected components engine.
//
// Usage:
//   in_ch  : items with kind = 0 load one adjacency row (vertex, targets bitmap);
//            kind = 1 starts a component search over vertices 0 .. count-1.
//   out_ch : one item per vertex of the graph in use, emitted as each component
//            is popped; the root closes its component (ends_component), and the
//            run's final item carries last.
//   cfg_we / cfg_wdata : write the vertex count; write only while the block idles.
// Timing:
//   A row load is taken while the block idles; loads can follow back to back. A run holds
//   in_ch.ready low until its search ends. A run steps through the roots tried,
//   the scan steps, the on-stack back edges, the vertices out of neighbors, the
//   result items, the returns to a parent frame and the finished roots; the
//   receiver's stalls add to its length.
// Reset: synchronous, active low; clears the row store, counters and the
//   vertex count to 32. When out_ch.ready is low the pending item holds and
//   the search waits.
module strongly_connected_components
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  scc_in_if.sink        in_ch,
  scc_out_if.source     out_ch
);

  scc_cmd_t  cmd;
  scc_stat_t stat;

  // Sequencer: owns the handshake and issues one step per cycle unless the result channel stalls it.
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath: holds the graph, the visit state and the result payload.
  scc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_vertex     (in_ch.vertex),
    .in_targets    (in_ch.targets),
    .cmd           (cmd),
    .stat          (stat),
    .res_member    (out_ch.member),
    .res_component (out_ch.component),
    .res_ends      (out_ch.ends_component),
    .res_last      (out_ch.last)
  );

`ifndef SYNTHESIS
  // No new item enters while a result is on offer.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result is pending");

  // A run item always takes the block busy on the next cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind) |=> !in_ch.ready)
    else $error("block ready right after a run started");

  // Nothing follows the final item of a run.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("result offered after the last item");
`endif

endmodule

// ===== test/strongly_connected_components_tb.sv =====
// Self-checking testbench for the strongly_connected_components block.
`timescale 1ns / 100ps

module strongly_connected_components_tb
  import scc_pkg::*;
();

  typedef struct {
    logic [VW-1:0] member;
    logic [VW-1:0] component;
    logic          ends_component;
    logic          last;
  } member_t;

  // One row of the directed part. A row either writes the vertex count or
  // sends one item. Runs marked fixed carry their expected answer in the row.
  typedef struct {
    bit            cfg_write;
    logic [CW-1:0] count;
    scc_kind_t     kind;
    logic [VW-1:0] vertex;
    logic [31:0]   targets;
    bit            fixed;
    int            n_fixed;
    member_t       fixed_result;
  } step_t;

  localparam member_t SOLO = '{member: 5'd0, component: 5'd0, ends_component: 1'b1,
                               last: 1'b1};
  localparam member_t NONE = '{member: 5'd0, component: 5'd0, ends_component: 1'b0,
                               last: 1'b0};

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  strongly_connected_components dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: the row store and the vertex count as the block sees them.
  logic [31:0]   graph_rows [32];
  logic [CW-1:0] vertex_count;

  member_t members_due [$];
  int      mismatches;
  bit      quiet;
  bit      fixed_item;   // rides along with the item on the input channel

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Work out the members of a run in the order the block pops them: Tarjan's
  // search with roots and neighbors in ascending order, explicit call stack.
  function automatic void predict_components();
    logic [5:0]    order [32];
    logic [4:0]    low [32];
    bit            onstk [32];
    logic [4:0]    comp_stack [32];
    logic [4:0]    frame_v [32];
    logic [5:0]    frame_pos [32];
    logic [31:0]   mask;
    logic [31:0]   pending;
    logic [4:0]    v;
    logic [4:0]    w;
    logic [4:0]    u;
    logic [5:0]    pos;
    logic [5:0]    counter;
    logic [4:0]    comp;
    int            n;
    int            depth;
    int            sp;
    bit            done;
    member_t       popped;
    member_t       run_members [$];
    n = (vertex_count > 32) ? 32 : int'(vertex_count);
    mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    for (int i = 0; i < 32; i++) begin
      order[i] = 6'd63;
      low[i] = '0;
      onstk[i] = 1'b0;
    end
    counter = '0;
    comp = '0;
    depth = 0;
    sp = 0;
    for (int root = 0; root < n; root++) begin
      if (order[root] != 6'd63) continue;
      order[root] = counter;
      low[root] = counter[4:0];
      counter++;
      comp_stack[sp] = 5'(root);
      sp++;
      onstk[root] = 1'b1;
      frame_v[depth] = 5'(root);
      frame_pos[depth] = '0;
      depth++;
      while (depth > 0) begin
        v = frame_v[depth-1];
        pos = frame_pos[depth-1];
        pending = (pos >= 32) ? '0 : (((graph_rows[v] & mask) >> pos) << pos);
        if (pending != 0) begin
          w = 5'd31;
          for (int b = 31; b >= 0; b--) begin
            if (pending[b]) w = 5'(b);
          end
          frame_pos[depth-1] = 6'(w) + 6'd1;
          if (order[w] == 6'd63) begin
            order[w] = counter;
            low[w] = counter[4:0];
            counter++;
            comp_stack[sp] = w;
            sp++;
            onstk[w] = 1'b1;
            frame_v[depth] = w;
            frame_pos[depth] = '0;
            depth++;
          end else if (onstk[w] && order[w] < 6'(low[v])) begin
            low[v] = order[w][4:0];
          end
          continue;
        end
        // Pop a finished component, root last.
        if (6'(low[v]) == order[v]) begin
          done = 1'b0;
          while (!done) begin
            w = comp_stack[sp-1];
            sp--;
            onstk[w] = 1'b0;
            popped.member         = w;
            popped.component      = comp;
            popped.ends_component = (w == v);
            popped.last           = 1'b0;
            run_members.insert(run_members.size(), popped);
            done = (w == v) || (sp == 0);
          end
          comp++;
        end
        depth--;
        if (depth > 0) begin
          u = frame_v[depth-1];
          if (low[v] < low[u]) low[u] = low[v];
        end
      end
    end
    if (run_members.size() > 0) run_members[$].last = 1'b1;
    foreach (run_members[i]) members_due.insert(members_due.size(), run_members[i]);
  endfunction

  // Track accepted items on both channels in one place, inputs first.
  always @(posedge clk) begin
    member_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.kind == KIND_LOAD) begin
        graph_rows[in_ch.vertex] <= in_ch.targets;
      end else if (!fixed_item) begin
        predict_components();
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (members_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected member item: member %0d component %0d end %b last %b",
                   $realtime, out_ch.member, out_ch.component, out_ch.ends_component,
                   out_ch.last);
      end else begin
        want = members_due.pop_front();
        if (out_ch.member !== want.member || out_ch.component !== want.component ||
            out_ch.ends_component !== want.ends_component || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: member item mismatch: expected %0d/%0d/%b/%b got %0d/%0d/%b/%b",
                     $realtime, want.member, want.component, want.ends_component,
                     want.last, out_ch.member, out_ch.component, out_ch.ends_component,
                     out_ch.last);
        end
      end
    end
  end

  // Stall the result channel in random bursts; stay open once quiet.
  always @(posedge clk) begin
    int stall;
    if (quiet || !rst_n) begin
      out_ch.ready <= 1'b1;
      stall = 0;
    end else if (stall > 0) begin
      out_ch.ready <= 1'b0;
      stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall = $urandom_range(1, 15) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one item; hold it until the block takes it.
  task automatic send_item(input scc_kind_t kind, input logic [VW-1:0] vertex,
                           input logic [31:0] targets, input bit fixed);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.vertex  <= vertex;
    in_ch.targets <= targets;
    fixed_item    <= fixed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Write the vertex count once the block has drained its last run.
  task automatic write_count(input logic [CW-1:0] count);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (members_due.size() != 0) @(posedge clk);
    // Wait for the search to return to idle, runs over zero vertices included.
    while (!in_ch.ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count = count;
  endtask

  task automatic run_table(input step_t steps [$]);
    foreach (steps[i]) begin
      if (steps[i].cfg_write) begin
        write_count(steps[i].count);
      end else begin
        if (steps[i].fixed && steps[i].n_fixed > 0)
          members_due.insert(members_due.size(), steps[i].fixed_result);
        send_item(steps[i].kind, steps[i].vertex, steps[i].targets, steps[i].fixed);
      end
    end
  endtask

  // Random graph row: sparse, dense, empty or all edges.
  function automatic logic [31:0] random_row(input int n);
    logic [31:0] row;
    case ($urandom_range(0, 7))
      0: row = '0;
      1: row = 32'hFFFF_FFFF;
      2: row = $urandom();
      default: row = $urandom() & $urandom() & $urandom();
    endcase
    // Mostly keep edges inside the graph so the search goes deep.
    if (n > 0 && n < 32 && $urandom_range(0, 3) != 0) begin
      row = row & ((32'd1 << n) - 32'd1);
      if ($urandom_range(0, 1)) row[$urandom_range(0, n - 1)] = 1'b1;
    end
    return row;
  endfunction

  initial begin
    step_t directed [$];
    int    sent;
    int    n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_LOAD;
    in_ch.vertex    = '0;
    in_ch.targets   = '0;
    fixed_item      = 1'b0;
    quiet           = 1'b0;
    mismatches      = 0;
    vertex_count    = NUM_RESET;
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      // Empty store after reset: every vertex is its own component.
      '{0, 0, KIND_RUN, 0, 0, 0, 0, NONE},
      // One vertex with a self loop and edges to vertices not in use.
      '{1, 1, KIND_LOAD, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 0, 32'hFFFF_FFFF, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 1, 1, SOLO},
      // Zero vertices: no members at all.
      '{1, 0, KIND_LOAD, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 1, 0, NONE},
      // Count above the store is clamped; vertices 0, 15 and 31 close a cycle.
      '{1, 6'd63, KIND_LOAD, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 5'd31, 32'hFFFF_FFFF, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 5'd15, 32'h8000_0000, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 0, 0, NONE},
      // Ring of three closed by a back edge, then a chain with a dead end.
      '{1, 4, KIND_LOAD, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 0, 32'h0000_0002, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 1, 32'h0000_0004, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 2, 32'h8000_0009, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 3, 32'h0000_0008, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_LOAD, 2, 32'h0000_0008, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 0, 0, NONE},
      '{1, 32, KIND_LOAD, 0, 0, 0, 0, NONE},
      '{0, 0, KIND_RUN, 0, 0, 0, 0, NONE}
    };
    run_table(directed);

    // Random phases: pick a count, load rows, run; a few phases use the extremes.
    sent = 0;
    while (sent < 400) begin
      case ($urandom_range(0, 9))
        0: n = 32;
        1: n = $urandom_range(0, 63);
        2: n = 1;
        default: n = $urandom_range(2, 10);
      endcase
      write_count(CW'(n));
      if (sent > 340) quiet = 1'b1;
      n = (n > 32) ? 32 : n;
      repeat ($urandom_range(1, (n > 0) ? n + 2 : 3)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(KIND_LOAD, 5'($urandom_range(0, 31)), $urandom(), 1'b0);
        else
          send_item(KIND_LOAD, 5'($urandom_range(0, (n > 0) ? n - 1 : 0)),
                    random_row(n), 1'b0);
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_item(KIND_RUN, 5'($urandom_range(0, 31)), $urandom(), 1'b0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (members_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && members_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/scc_pkg.sv
sv/scc_in_if.sv
sv/scc_out_if.sv
sv/scc_ctrl.sv
sv/scc_dpath.sv
sv/strongly_connected_components.sv
test/strongly_connected_components_tb.sv
